@@ rtl/dfs_pkg.sv @@
// Shared constants for the depth-first spanning forest block.
package dfs_pkg;

    // Default capacity of the adjacency matrix and search stack.
    localparam int MAX_VERTICES_DEF = 32;

    // Fixed payload widths.
    localparam int REQ_W   = 2;
    localparam int VERT_W  = 5;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 6;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Result codes.
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TREE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

    // Register port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_VCOUNT = 1'b0;
    localparam logic [COUNT_W-1:0] VCOUNT_RESET = 6'd32;

endpackage

@@ rtl/dfs_if.sv @@
// Request and result channel interfaces of the spanning forest block.
interface dfs_req_if;
    logic                        valid;
    logic                        ready;
    logic [dfs_pkg::REQ_W-1:0]   req_type;
    logic [dfs_pkg::VERT_W-1:0]  vert_a;
    logic [dfs_pkg::VERT_W-1:0]  vert_b;

    modport source (output valid, req_type, vert_a, vert_b, input ready);
    modport sink   (input valid, req_type, vert_a, vert_b, output ready);
endinterface

interface dfs_res_if;
    logic                        valid;
    logic                        ready;
    logic [dfs_pkg::KIND_W-1:0]  kind;
    logic [dfs_pkg::VERT_W-1:0]  parent_vertex;
    logic [dfs_pkg::VERT_W-1:0]  child_vertex;
    logic [dfs_pkg::COUNT_W-1:0] component_count;
    logic                        last;

    modport source (output valid, kind, parent_vertex, child_vertex, component_count, last,
                    input ready);
    modport sink   (input valid, kind, parent_vertex, child_vertex, component_count, last,
                    output ready);
endinterface

@@ rtl/dfs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dfs_spanning_forest.sv @@
// Depth-first spanning forest engine over an adjacency bit matrix held in RAM.
//
// Usage:
//   i_req carries one request per transaction: add edge (vert_a, vert_b), run
//   search, or clear the matrix. o_res returns results; every request that
//   yields results ends with one result marked last. The APB vertex_count register
//   at byte address 0 must be written only while idle; this is not enforced.
// Sequencing:
//   An add-edge request reads and writes both adjacency rows through the
//   single RAM port pair: it reads row a, then writes row a while reading
//   row b, then writes row b and presents its acknowledgement; a rejected
//   edge goes straight to the acknowledgement. A clear and a request code
//   without meaning are handled in the idle state. A search descends a tree
//   edge through a row fetch, pops through a stack RAM read and a row
//   refetch, opens a tree with a row fetch, and closes it by returning to
//   root selection, which presents the done result when no vertex is left.
// Reset:
//   Clear all row valid bits (an empty matrix), the visit mask, the stack
//   depth and the output valid bit; vertex_count returns to 32.
// Stall:
//   A finished result waits in the output register; a state that must launch
//   the next result holds until the receiver takes it. New requests are taken
//   only between requests.
module dfs_spanning_forest #(
    parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dfs_req_if.sink                     i_req,
    dfs_res_if.source                   o_res,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [dfs_pkg::APB_AW-1:0]  i_paddr,
    input  logic [dfs_pkg::APB_DW-1:0]  i_pwdata,
    output logic [dfs_pkg::APB_DW-1:0]  o_prdata,
    output logic                        o_pready
);

    localparam int VW = $clog2(MAX_VERTICES);      // vertex index width
    localparam int CW = $clog2(MAX_VERTICES + 1);  // count width, holds MAX_VERTICES
    localparam int SW = VW + CW;                   // stack entry: vertex and next neighbor

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_ADD_WA   = 8'b0000_0010,
        ST_ADD_WB   = 8'b0000_0100,
        ST_ACK      = 8'b0000_1000,
        ST_ROOT     = 8'b0001_0000,
        ST_ROW_WAIT = 8'b0010_0000,
        ST_SCAN     = 8'b0100_0000,
        ST_POP_WAIT = 8'b1000_0000
    } t_state;

    // Index of the set bit of a one-hot word.
    function automatic logic [VW-1:0] onehot_index(input logic [MAX_VERTICES-1:0] oh);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (oh[i]) begin
                idx = idx | VW'(i);
            end
        end
        return idx;
    endfunction

    // Control and datapath registers.
    t_state                        r_state, n_state;
    logic [dfs_pkg::COUNT_W-1:0]   r_vcount;
    logic [MAX_VERTICES-1:0]       r_rowvld, n_rowvld;
    logic [MAX_VERTICES-1:0]       r_visited, n_visited;
    logic [MAX_VERTICES-1:0]       r_row, n_row;
    logic [VW-1:0]                 r_v, n_v;
    logic [CW-1:0]                 r_next, n_next;
    logic [CW-1:0]                 r_depth, n_depth;
    logic [CW-1:0]                 r_comps, n_comps;
    logic [VW-1:0]                 r_a, n_a;
    logic [VW-1:0]                 r_b, n_b;
    logic [dfs_pkg::KIND_W-1:0]    r_kind, n_kind;
    logic                          r_rdvld;

    // Output register.
    logic                          r_ovalid;
    logic [dfs_pkg::KIND_W-1:0]    r_okind;
    logic [dfs_pkg::VERT_W-1:0]    r_opar;
    logic [dfs_pkg::VERT_W-1:0]    r_ochi;
    logic [dfs_pkg::COUNT_W-1:0]   r_ocomp;
    logic                          r_olast;

    // Result launch.
    logic                          emit;
    logic [dfs_pkg::KIND_W-1:0]    e_kind;
    logic [dfs_pkg::VERT_W-1:0]    e_par;
    logic [dfs_pkg::VERT_W-1:0]    e_chi;
    logic [dfs_pkg::COUNT_W-1:0]   e_comp;
    logic                          e_last;
    logic                          out_free;

    // RAM ports.
    logic                          adj_we, adj_re;
    logic [VW-1:0]                 adj_wa, adj_ra;
    logic [MAX_VERTICES-1:0]       adj_wd, adj_rd;
    logic                          stk_we, stk_re;
    logic [VW-1:0]                 stk_wa, stk_ra;
    logic [SW-1:0]                 stk_wd, stk_rd;

    // Search combinational terms.
    logic [CW-1:0]                 w_n;
    logic [MAX_VERTICES-1:0]       w_lt_n;
    logic [MAX_VERTICES-1:0]       w_ge_next;
    logic [MAX_VERTICES-1:0]       w_root_c, w_root_oh;
    logic [MAX_VERTICES-1:0]       w_nb_c, w_nb_oh;
    logic [VW-1:0]                 w_root_idx, w_nb_idx;
    logic [MAX_VERTICES-1:0]       w_base;
    logic [MAX_VERTICES-1:0]       w_bit_a, w_bit_b;
    logic                          w_req_acc;
    logic                          w_edge_ok;
    logic                          w_cfg_wr;

    assign w_req_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign out_free = !r_ovalid || o_res.ready;

    // Effective vertex count: clamp to the matrix size.
    always_comb begin
        if (int'(r_vcount) > MAX_VERTICES) begin
            w_n = CW'(MAX_VERTICES);
        end else begin
            w_n = CW'(r_vcount);
        end
    end

    assign w_edge_ok = (int'(i_req.vert_a) < int'(w_n)) && (int'(i_req.vert_b) < int'(w_n));

    // Column masks for the active range and for the scan start of the top entry.
    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_lt_n[i]    = (i < int'(w_n));
            w_ge_next[i] = (i >= int'(r_next));
        end
    end

    // Next root: lowest unvisited active vertex.
    assign w_root_c   = ~r_visited & w_lt_n;
    assign w_root_oh  = w_root_c & (~w_root_c + 1'b1);
    assign w_root_idx = onehot_index(w_root_oh);

    // Next neighbor: lowest unvisited edge at or after the scan position.
    assign w_nb_c   = r_row & ~r_visited & w_lt_n & w_ge_next;
    assign w_nb_oh  = w_nb_c & (~w_nb_c + 1'b1);
    assign w_nb_idx = onehot_index(w_nb_oh);

    // Rows never written since the last clear read as empty.
    assign w_base = r_rdvld ? adj_rd : '0;

    always_comb begin
        w_bit_a = '0;
        w_bit_b = '0;
        w_bit_a[r_a] = 1'b1;
        w_bit_b[r_b] = 1'b1;
    end

    always_comb begin
        n_state   = r_state;
        n_rowvld  = r_rowvld;
        n_visited = r_visited;
        n_row     = r_row;
        n_v       = r_v;
        n_next    = r_next;
        n_depth   = r_depth;
        n_comps   = r_comps;
        n_a       = r_a;
        n_b       = r_b;
        n_kind    = r_kind;
        adj_we    = 1'b0;
        adj_wa    = '0;
        adj_wd    = '0;
        adj_re    = 1'b0;
        adj_ra    = '0;
        stk_we    = 1'b0;
        stk_wa    = '0;
        stk_wd    = '0;
        stk_re    = 1'b0;
        stk_ra    = '0;
        emit      = 1'b0;
        e_kind    = dfs_pkg::KIND_ACCEPT;
        e_par     = '0;
        e_chi     = '0;
        e_comp    = '0;
        e_last    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_req_acc) begin
                    unique case (i_req.req_type)
                        dfs_pkg::REQ_ADD: begin
                            if (w_edge_ok) begin
                                // Fetch row a now; row b follows on the write of row a.
                                n_a     = VW'(i_req.vert_a);
                                n_b     = VW'(i_req.vert_b);
                                adj_re  = 1'b1;
                                adj_ra  = VW'(i_req.vert_a);
                                n_state = ST_ADD_WA;
                            end else begin
                                n_kind  = dfs_pkg::KIND_REJECT;
                                n_state = ST_ACK;
                            end
                        end
                        dfs_pkg::REQ_RUN: begin
                            n_visited = '0;
                            n_comps   = '0;
                            n_depth   = '0;
                            n_state   = ST_ROOT;
                        end
                        dfs_pkg::REQ_CLEAR: begin
                            n_rowvld = '0;
                        end
                        default: begin
                            // Drop requests with no meaning.
                        end
                    endcase
                end
            end

            ST_ADD_WA: begin
                adj_we   = 1'b1;
                adj_wa   = r_a;
                adj_wd   = w_base | w_bit_b;
                n_rowvld[r_a] = 1'b1;
                adj_re   = 1'b1;
                adj_ra   = r_b;
                n_state  = ST_ADD_WB;
            end

            ST_ADD_WB: begin
                adj_we   = 1'b1;
                adj_wa   = r_b;
                adj_wd   = w_base | w_bit_a;
                n_rowvld[r_b] = 1'b1;
                n_kind   = dfs_pkg::KIND_ACCEPT;
                n_state  = ST_ACK;
            end

            ST_ACK: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = r_kind;
                    e_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_ROOT: begin
                if (|w_root_c) begin
                    n_comps   = r_comps + CW'(1);
                    n_visited = r_visited | w_root_oh;
                    n_v       = w_root_idx;
                    n_next    = '0;
                    n_depth   = CW'(1);
                    adj_re    = 1'b1;
                    adj_ra    = w_root_idx;
                    n_state   = ST_ROW_WAIT;
                end else if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = dfs_pkg::KIND_DONE;
                    e_comp  = dfs_pkg::COUNT_W'(r_comps);
                    e_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_ROW_WAIT: begin
                n_row   = w_base;
                n_state = ST_SCAN;
            end

            ST_SCAN: begin
                if (|w_nb_c) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        e_kind    = dfs_pkg::KIND_TREE;
                        e_par     = dfs_pkg::VERT_W'(r_v);
                        e_chi     = dfs_pkg::VERT_W'(w_nb_idx);
                        n_visited = r_visited | w_nb_oh;
                        if (r_depth < CW'(MAX_VERTICES)) begin
                            // Push the current top with its resume point, descend.
                            stk_we  = 1'b1;
                            stk_wa  = VW'(r_depth - CW'(1));
                            stk_wd  = {r_v, CW'(w_nb_idx) + CW'(1)};
                            n_v     = w_nb_idx;
                            n_next  = '0;
                            n_depth = r_depth + CW'(1);
                            adj_re  = 1'b1;
                            adj_ra  = w_nb_idx;
                            n_state = ST_ROW_WAIT;
                        end else begin
                            // Stack full: keep scanning the same row.
                            n_next = CW'(w_nb_idx) + CW'(1);
                        end
                    end
                end else if (r_depth == CW'(1)) begin
                    n_depth = '0;
                    n_state = ST_ROOT;
                end else begin
                    n_depth = r_depth - CW'(1);
                    stk_re  = 1'b1;
                    stk_ra  = VW'(r_depth - CW'(2));
                    n_state = ST_POP_WAIT;
                end
            end

            ST_POP_WAIT: begin
                // Restore the parent entry and refetch its row.
                n_v     = stk_rd[SW-1:CW];
                n_next  = stk_rd[CW-1:0];
                adj_re  = 1'b1;
                adj_ra  = stk_rd[SW-1:CW];
                n_state = ST_ROW_WAIT;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rowvld  <= '0;
            r_visited <= '0;
            r_depth   <= '0;
            r_comps   <= '0;
        end else begin
            r_state   <= n_state;
            r_rowvld  <= n_rowvld;
            r_visited <= n_visited;
            r_depth   <= n_depth;
            r_comps   <= n_comps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_v    <= n_v;
        r_next <= n_next;
        r_a    <= n_a;
        r_b    <= n_b;
        r_kind <= n_kind;
        // Track whether the row being fetched holds data since the last clear.
        if (adj_re) begin
            r_rdvld <= r_rowvld[adj_ra];
        end
    end

    // Output register: load on launch, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_okind <= e_kind;
            r_opar  <= e_par;
            r_ochi  <= e_chi;
            r_ocomp <= e_comp;
            r_olast <= e_last;
        end
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.kind            = r_okind;
    assign o_res.parent_vertex   = r_opar;
    assign o_res.child_vertex    = r_ochi;
    assign o_res.component_count = r_ocomp;
    assign o_res.last            = r_olast;

    // Register port.
    assign w_cfg_wr = i_psel && i_penable && i_pwrite
                      && (i_paddr[dfs_pkg::APB_AW-1:2] == dfs_pkg::REG_VCOUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= dfs_pkg::VCOUNT_RESET;
        end else if (w_cfg_wr) begin
            r_vcount <= i_pwdata[dfs_pkg::COUNT_W-1:0];
        end
    end

    assign o_prdata = (i_paddr[dfs_pkg::APB_AW-1:2] == dfs_pkg::REG_VCOUNT)
                      ? dfs_pkg::APB_DW'(r_vcount) : '0;
    assign o_pready = 1'b1;

    // Adjacency matrix, one row per vertex.
    dfs_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_wa),
        .i_wdata (adj_wd),
        .i_re    (adj_re),
        .i_raddr (adj_ra),
        .o_rdata (adj_rd)
    );

    // Search stack below the top entry.
    dfs_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_VERTICES)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_wa),
        .i_wdata (stk_wd),
        .i_re    (stk_re),
        .i_raddr (stk_ra),
        .o_rdata (stk_rd)
    );

endmodule

@@ rtl/dfs_chk.sv @@
// Port-level checker for the spanning forest block, bound to its top level.
module dfs_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic [dfs_pkg::REQ_W-1:0]    i_req_type,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic [dfs_pkg::KIND_W-1:0]   i_kind,
    input logic [dfs_pkg::VERT_W-1:0]   i_parent,
    input logic [dfs_pkg::VERT_W-1:0]   i_child,
    input logic [dfs_pkg::COUNT_W-1:0]  i_comp,
    input logic                         i_last
);

    // Hold a stalled result.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_kind) && $stable(i_parent)
            && $stable(i_child) && $stable(i_comp) && $stable(i_last))
        else $error("stalled result changed");

    // Only tree edges leave a request open.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_last == (i_kind != dfs_pkg::KIND_TREE)))
        else $error("last flag does not match result kind");

    // An add or a search keeps the request channel busy in the cycle after it is taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready
            && (i_req_type == dfs_pkg::REQ_ADD || i_req_type == dfs_pkg::REQ_RUN)
        |=> !i_req_ready)
        else $error("request taken while previous one is in progress");

endmodule

bind dfs_spanning_forest dfs_chk u_dfs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_kind      (o_res.kind),
    .i_parent    (o_res.parent_vertex),
    .i_child     (o_res.child_vertex),
    .i_comp      (o_res.component_count),
    .i_last      (o_res.last)
);
